>>> hw/rtl/pfp_pkg.sv
// ----------------------------------------------------------------------------
// Page fit placement package
// Shared widths, register indexes, mode bits and the configuration record.
// ----------------------------------------------------------------------------
package pfp_pkg;

  localparam int PTS_W      = 20;
  localparam int DPI_W      = 13;
  localparam int BND_W      = 16;
  localparam int POS_W      = 17;
  localparam int MODE_W     = 5;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_DPI_H = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DPI_V = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LEFT  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_TOP   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_WIDE  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_TALL  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_MODE  = 3'd6;

  localparam int MODE_AUTOROT = 0;
  localparam int MODE_FIT     = 1;
  localparam int MODE_STRETCH = 2;
  localparam int MODE_KEEP    = 3;
  localparam int MODE_CENTER  = 4;

  localparam logic [DPI_W-1:0] DPI_RESET  = 13'd72;
  localparam logic [BND_W-1:0] SIZE_RESET = 16'd1;

  // 1152 units per inch = 128 * 9: a shift by 7, then a reciprocal of 9.
  localparam int                UNITS_SHIFT = 7;
  localparam int                RECIP_W     = 27;
  localparam int                RECIP_SHIFT = 30;
  localparam logic [RECIP_W-1:0] RECIP_9    = 27'd119304648;

  typedef struct packed {
    logic [DPI_W-1:0]        dpi_h;
    logic [DPI_W-1:0]        dpi_v;
    logic signed [BND_W-1:0] left;
    logic signed [BND_W-1:0] top;
    logic [BND_W-1:0]        wide;
    logic [BND_W-1:0]        tall;
    logic [MODE_W-1:0]       mode;
  } cfg_t;

  function automatic logic [DPI_W-1:0] dpi_max(input cfg_t c);
    return (c.dpi_h > c.dpi_v) ? c.dpi_h : c.dpi_v;
  endfunction

endpackage

>>> hw/rtl/pfp_div.sv
// ----------------------------------------------------------------------------
// Pipelined restoring divider
// Two quotient bits per stage; the numerator must be below den * 2^QW.
// ----------------------------------------------------------------------------
module pfp_div #(
  parameter int NW = 32,
  parameter int DW = 16,
  parameter int QW = 16,
  parameter int TW = 1
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  input  logic [TW-1:0] tag,
  output logic          out_valid,
  input  logic          out_ready,
  output logic [QW-1:0] quo,
  output logic [TW-1:0] tag_out
);

  localparam int STAGES = (QW + 1) / 2;

  logic          v   [1:STAGES];
  logic          rdy [1:STAGES+1];
  logic [DW-1:0] rem [1:STAGES];
  logic [QW-1:0] lo  [1:STAGES];
  logic [QW-1:0] qa  [1:STAGES];
  logic [DW-1:0] dv  [1:STAGES];
  logic [TW-1:0] tg  [1:STAGES];

  assign rdy[STAGES+1] = out_ready;
  assign in_ready      = rdy[1];

  for (genvar s = 1; s <= STAGES; s++) begin : g_stage
    logic          p_v;
    logic [DW-1:0] p_rem;
    logic [QW-1:0] p_lo;
    logic [QW-1:0] p_q;
    logic [DW-1:0] p_d;
    logic [TW-1:0] p_tg;
    logic [DW-1:0] r;
    logic [QW-1:0] l;
    logic [QW-1:0] q;
    logic [DW:0]   t;

    if (s == 1) begin : g_first
      assign p_v   = in_valid;
      assign p_rem = DW'(num[NW-1:QW]);
      assign p_lo  = num[QW-1:0];
      assign p_q   = '0;
      assign p_d   = den;
      assign p_tg  = tag;
    end else begin : g_next
      assign p_v   = v[s-1];
      assign p_rem = rem[s-1];
      assign p_lo  = lo[s-1];
      assign p_q   = qa[s-1];
      assign p_d   = dv[s-1];
      assign p_tg  = tg[s-1];
    end

    assign rdy[s] = !v[s] || rdy[s+1];

    always_comb begin
      r = p_rem;
      l = p_lo;
      q = p_q;
      t = '0;
      for (int j = 0; j < 2; j++) begin
        if ((s - 1) * 2 + j < QW) begin
          t = {r, l[QW-1]};
          l = l << 1;
          if (t >= {1'b0, p_d}) begin
            t = t - {1'b0, p_d};
            q = {q[QW-2:0], 1'b1};
          end else begin
            q = {q[QW-2:0], 1'b0};
          end
          r = t[DW-1:0];
        end
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        v[s] <= 1'b0;
      end else if (rdy[s]) begin
        v[s] <= p_v;
      end
    end

    always_ff @(posedge clk) begin
      if (rdy[s]) begin
        rem[s] <= r;
        lo[s]  <= l;
        qa[s]  <= q;
        dv[s]  <= p_d;
        tg[s]  <= p_tg;
      end
    end
  end

  assign out_valid = v[STAGES];
  assign quo       = qa[STAGES];
  assign tag_out   = tg[STAGES];

endmodule

>>> hw/rtl/pfp_convert.sv
// ----------------------------------------------------------------------------
// Point to pixel conversion
// Three stages: size times dpi, reciprocal multiply, saturate.
// ----------------------------------------------------------------------------
module pfp_convert #(
  parameter int SIZE_BITS = 16
) (
  input  logic                       clk,
  input  logic                       rst,
  input  pfp_pkg::cfg_t              cfg,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [pfp_pkg::PTS_W-1:0]  width_pts,
  input  logic [pfp_pkg::PTS_W-1:0]  height_pts,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [SIZE_BITS-1:0]       width_px,
  output logic [SIZE_BITS-1:0]       height_px
);

  localparam int PROD_W = pfp_pkg::PTS_W + pfp_pkg::DPI_W;
  localparam int Y_W    = PROD_W - pfp_pkg::UNITS_SHIFT;
  localparam int M_W    = Y_W + pfp_pkg::RECIP_W;
  localparam int Q_W    = M_W - pfp_pkg::RECIP_SHIFT;
  localparam logic [SIZE_BITS-1:0] LIMIT = '1;

  function automatic logic [SIZE_BITS-1:0] saturate(input logic [Q_W-1:0] q);
    if (32'(q) > 32'(LIMIT)) begin
      return LIMIT;
    end
    return SIZE_BITS'(q);
  endfunction

  logic                   v1, v2, v3;
  logic                   r1, r2, r3;
  logic [pfp_pkg::DPI_W-1:0] dpi;
  logic [PROD_W-1:0]      p1w, p1h;
  logic [M_W-1:0]         m2w, m2h;

  assign dpi      = pfp_pkg::dpi_max(cfg);
  assign r3       = !v3 || out_ready;
  assign r2       = !v2 || r3;
  assign r1       = !v1 || r2;
  assign in_ready = r1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      if (r1) begin
        v1 <= in_valid;
      end
      if (r2) begin
        v2 <= v1;
      end
      if (r3) begin
        v3 <= v2;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (r1) begin
      p1w <= PROD_W'(width_pts) * PROD_W'(dpi);
      p1h <= PROD_W'(height_pts) * PROD_W'(dpi);
    end
    if (r2) begin
      m2w <= M_W'(p1w[PROD_W-1:pfp_pkg::UNITS_SHIFT]) * M_W'(pfp_pkg::RECIP_9);
      m2h <= M_W'(p1h[PROD_W-1:pfp_pkg::UNITS_SHIFT]) * M_W'(pfp_pkg::RECIP_9);
    end
    if (r3) begin
      width_px  <= saturate(m2w[M_W-1:pfp_pkg::RECIP_SHIFT]);
      height_px <= saturate(m2h[M_W-1:pfp_pkg::RECIP_SHIFT]);
    end
  end

  assign out_valid = v3;

endmodule

>>> hw/rtl/pfp_aspect.sv
// ----------------------------------------------------------------------------
// Orientation, scale decision and keep-aspect quotient
// Swaps the page, cross-multiplies against the bounds and divides.
// ----------------------------------------------------------------------------
module pfp_aspect #(
  parameter int SIZE_BITS = 16,
  localparam int VW = (SIZE_BITS > pfp_pkg::BND_W) ? SIZE_BITS : pfp_pkg::BND_W
) (
  input  logic                 clk,
  input  logic                 rst,
  input  pfp_pkg::cfg_t        cfg,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [SIZE_BITS-1:0] width_px,
  input  logic [SIZE_BITS-1:0] height_px,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [VW-1:0]        fit_w,
  output logic [VW-1:0]        fit_h,
  output logic                 rot
);

  localparam int XW = SIZE_BITS + pfp_pkg::BND_W;

  typedef struct packed {
    logic                 rot;
    logic                 scale;
    logic                 wide;
    logic                 zero;
    logic [SIZE_BITS-1:0] pw;
    logic [SIZE_BITS-1:0] ph;
  } atag_t;

  logic                 v4, v5, v6, v7;
  logic                 r4, r5, r6, r7;
  logic                 div_ready, div_valid;
  logic                 rot_c, big_c, small_c, scale_c;
  logic [SIZE_BITS-1:0] pw_c, ph_c;
  logic [SIZE_BITS-1:0] pw4, ph4, pw5, ph5;
  logic                 rot4, scale4, rot5, scale5;
  logic [XW-1:0]        a5, b5, num6;
  logic [SIZE_BITS-1:0] den6;
  atag_t                tag6, dtag;
  logic                 wide_c;
  logic [pfp_pkg::BND_W-1:0] quo;
  logic [VW-1:0]        wc, hc;

  always_comb begin
    rot_c   = cfg.mode[pfp_pkg::MODE_AUTOROT] &&
              ((cfg.wide > cfg.tall) != (width_px > height_px));
    pw_c    = rot_c ? height_px : width_px;
    ph_c    = rot_c ? width_px : height_px;
    big_c   = (VW'(pw_c) > VW'(cfg.wide)) || (VW'(ph_c) > VW'(cfg.tall));
    small_c = (VW'(pw_c) < VW'(cfg.wide)) || (VW'(ph_c) < VW'(cfg.tall));
    scale_c = (cfg.mode[pfp_pkg::MODE_FIT] && big_c) ||
              (cfg.mode[pfp_pkg::MODE_STRETCH] && small_c);
    wide_c  = a5 > b5;
  end

  assign r7       = !v7 || out_ready;
  assign r6       = !v6 || div_ready;
  assign r5       = !v5 || r6;
  assign r4       = !v4 || r5;
  assign in_ready = r4;

  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
      v5 <= 1'b0;
      v6 <= 1'b0;
      v7 <= 1'b0;
    end else begin
      if (r4) begin
        v4 <= in_valid;
      end
      if (r5) begin
        v5 <= v4;
      end
      if (r6) begin
        v6 <= v5;
      end
      if (r7) begin
        v7 <= div_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (r4) begin
      pw4    <= pw_c;
      ph4    <= ph_c;
      rot4   <= rot_c;
      scale4 <= scale_c;
    end
    if (r5) begin
      a5     <= XW'(pw4) * XW'(cfg.tall);
      b5     <= XW'(ph4) * XW'(cfg.wide);
      pw5    <= pw4;
      ph5    <= ph4;
      rot5   <= rot4;
      scale5 <= scale4;
    end
    if (r6) begin
      num6       <= wide_c ? b5 : a5;
      den6       <= wide_c ? pw5 : ph5;
      tag6.rot   <= rot5;
      tag6.scale <= scale5;
      tag6.wide  <= wide_c;
      tag6.zero  <= (ph5 == '0);
      tag6.pw    <= pw5;
      tag6.ph    <= ph5;
    end
  end

  pfp_div #(
    .NW (XW),
    .DW (SIZE_BITS),
    .QW (pfp_pkg::BND_W),
    .TW ($bits(atag_t))
  ) u_div (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (v6),
    .in_ready  (div_ready),
    .num       (num6),
    .den       (den6),
    .tag       (tag6),
    .out_valid (div_valid),
    .out_ready (r7),
    .quo       (quo),
    .tag_out   (dtag)
  );

  always_comb begin
    if (!dtag.scale) begin
      wc = VW'(dtag.pw);
      hc = VW'(dtag.ph);
    end else begin
      wc = VW'(cfg.wide);
      hc = VW'(cfg.tall);
      if (cfg.mode[pfp_pkg::MODE_KEEP]) begin
        if (dtag.wide) begin
          hc = VW'(quo);
        end else if (dtag.zero) begin
          wc = '0;
        end else begin
          wc = VW'(quo);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (r7) begin
      fit_w <= wc;
      fit_h <= hc;
      rot   <= dtag.rot;
    end
  end

  assign out_valid = v7;

endmodule

>>> hw/rtl/pfp_place.sv
// ----------------------------------------------------------------------------
// Resolution rescale and centering
// Rescales the lower-dpi axis of size and bounds, then centers in center mode.
// ----------------------------------------------------------------------------
module pfp_place #(
  parameter int SIZE_BITS = 16,
  localparam int VW = (SIZE_BITS > pfp_pkg::BND_W) ? SIZE_BITS : pfp_pkg::BND_W
) (
  input  logic                      clk,
  input  logic                      rst,
  input  pfp_pkg::cfg_t             cfg,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [VW-1:0]             fit_w,
  input  logic [VW-1:0]             fit_h,
  input  logic                      rot,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [pfp_pkg::POS_W-1:0] dest_left,
  output logic [pfp_pkg::POS_W-1:0] dest_top,
  output logic [pfp_pkg::BND_W-1:0] dest_width,
  output logic [pfp_pkg::BND_W-1:0] dest_height,
  output logic                      rotated
);

  localparam int NW = VW + pfp_pkg::DPI_W;

  typedef struct packed {
    logic [VW-1:0] w;
    logic [VW-1:0] h;
  } ptag_t;

  logic                      v1, r1, vo, ro;
  logic                      va, vb, ra, rb;
  logic                      small_x, needs;
  logic [pfp_pkg::DPI_W-1:0] ds, db, den1;
  logic [NW-1:0]             na, nb;
  ptag_t                     tag1, tag_a;
  logic                      rot1, rot_b;
  logic [VW-1:0]             qa, qb;
  logic [VW-1:0]             wf, hf, rw, rh;
  logic signed [31:0]        dx, dy, left_c, top_c;

  assign small_x  = cfg.dpi_h < cfg.dpi_v;
  assign needs    = cfg.dpi_h != cfg.dpi_v;
  assign ds       = small_x ? cfg.dpi_h : cfg.dpi_v;
  assign db       = small_x ? cfg.dpi_v : cfg.dpi_h;

  assign ro       = !vo || out_ready;
  assign r1       = !v1 || (ra && rb);
  assign in_ready = r1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      vo <= 1'b0;
    end else begin
      if (r1) begin
        v1 <= in_valid;
      end
      if (ro) begin
        vo <= va && vb;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (r1) begin
      na     <= NW'(small_x ? fit_w : fit_h) * NW'(ds);
      nb     <= NW'(small_x ? VW'(cfg.wide) : VW'(cfg.tall)) * NW'(ds);
      den1   <= db;
      tag1.w <= fit_w;
      tag1.h <= fit_h;
      rot1   <= rot;
    end
  end

  pfp_div #(
    .NW (NW),
    .DW (pfp_pkg::DPI_W),
    .QW (VW),
    .TW ($bits(ptag_t))
  ) u_div_size (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (v1),
    .in_ready  (ra),
    .num       (na),
    .den       (den1),
    .tag       (tag1),
    .out_valid (va),
    .out_ready (ro),
    .quo       (qa),
    .tag_out   (tag_a)
  );

  pfp_div #(
    .NW (NW),
    .DW (pfp_pkg::DPI_W),
    .QW (VW),
    .TW (1)
  ) u_div_bounds (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (v1),
    .in_ready  (rb),
    .num       (nb),
    .den       (den1),
    .tag       (rot1),
    .out_valid (vb),
    .out_ready (ro),
    .quo       (qb),
    .tag_out   (rot_b)
  );

  always_comb begin
    wf = (needs && small_x) ? qa : tag_a.w;
    hf = (needs && !small_x) ? qa : tag_a.h;
    rw = (needs && small_x) ? qb : VW'(cfg.wide);
    rh = (needs && !small_x) ? qb : VW'(cfg.tall);
    dx = $signed(32'(rw)) - $signed(32'(wf));
    dy = $signed(32'(rh)) - $signed(32'(hf));
    left_c = 32'(cfg.left);
    top_c  = 32'(cfg.top);
    if (cfg.mode[pfp_pkg::MODE_CENTER]) begin
      left_c = left_c + ((dx + $signed(32'(dx[31]))) >>> 1);
      top_c  = top_c + ((dy + $signed(32'(dy[31]))) >>> 1);
    end
  end

  always_ff @(posedge clk) begin
    if (ro) begin
      dest_left   <= left_c[pfp_pkg::POS_W-1:0];
      dest_top    <= top_c[pfp_pkg::POS_W-1:0];
      dest_width  <= wf[pfp_pkg::BND_W-1:0];
      dest_height <= hf[pfp_pkg::BND_W-1:0];
      rotated     <= rot_b;
    end
  end

  assign out_valid = vo;

endmodule

>>> hw/rtl/page_fit_placement.sv
// ----------------------------------------------------------------------------
// Page fit placement
// Places a page given in points into a bounds rectangle in pixels.
// ----------------------------------------------------------------------------
// The input channel takes a page width and height (points, four fraction
// bits) on in_valid while in_stall is low. Each transaction gives one result
// on the output channel: the placed rectangle and a rotate flag, taken when
// out_valid is high and out_stall is low.
// Registers are written over the configuration channel (cfg_valid and
// cfg_ready); cfg_ready is always high. Write them only while no
// transaction is in flight.
// One transaction is accepted every cycle while out_stall is low. The
// pipeline holds the keep-aspect divider (eight stages) and the rescale
// dividers, which both retire two quotient bits per stage.
// A stall on the output holds the last stage; bubbles inside the pipeline
// still fill, and in_stall rises only when every stage holds a transaction.
// Reset empties the pipeline and loads the register reset values.
// ----------------------------------------------------------------------------
module page_fit_placement #(
  parameter int SIZE_BITS = 16
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [pfp_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [pfp_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [pfp_pkg::PTS_W-1:0]      page_width_pts,
  input  logic [pfp_pkg::PTS_W-1:0]      page_height_pts,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic signed [pfp_pkg::POS_W-1:0] dest_left,
  output logic signed [pfp_pkg::POS_W-1:0] dest_top,
  output logic [pfp_pkg::BND_W-1:0]      dest_width,
  output logic [pfp_pkg::BND_W-1:0]      dest_height,
  output logic                           rotated
);

  localparam int VW = (SIZE_BITS > pfp_pkg::BND_W) ? SIZE_BITS : pfp_pkg::BND_W;

  pfp_pkg::cfg_t        cfg;
  logic                 cv_valid, cv_ready, as_valid, as_ready, in_ready;
  logic [SIZE_BITS-1:0] pw, ph;
  logic [VW-1:0]        fit_w, fit_h;
  logic                 fit_rot;
  logic [pfp_pkg::POS_W-1:0] left_u, top_u;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.dpi_h <= pfp_pkg::DPI_RESET;
      cfg.dpi_v <= pfp_pkg::DPI_RESET;
      cfg.left  <= '0;
      cfg.top   <= '0;
      cfg.wide  <= pfp_pkg::SIZE_RESET;
      cfg.tall  <= pfp_pkg::SIZE_RESET;
      cfg.mode  <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        pfp_pkg::REG_DPI_H: cfg.dpi_h <= cfg_data[pfp_pkg::DPI_W-1:0];
        pfp_pkg::REG_DPI_V: cfg.dpi_v <= cfg_data[pfp_pkg::DPI_W-1:0];
        pfp_pkg::REG_LEFT:  cfg.left  <= cfg_data;
        pfp_pkg::REG_TOP:   cfg.top   <= cfg_data;
        pfp_pkg::REG_WIDE:  cfg.wide  <= cfg_data;
        pfp_pkg::REG_TALL:  cfg.tall  <= cfg_data;
        pfp_pkg::REG_MODE:  cfg.mode  <= cfg_data[pfp_pkg::MODE_W-1:0];
        default: begin
        end
      endcase
    end
  end

  pfp_convert #(.SIZE_BITS(SIZE_BITS)) u_convert (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .width_pts  (page_width_pts),
    .height_pts (page_height_pts),
    .out_valid  (cv_valid),
    .out_ready  (cv_ready),
    .width_px   (pw),
    .height_px  (ph)
  );

  pfp_aspect #(.SIZE_BITS(SIZE_BITS)) u_aspect (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_valid  (cv_valid),
    .in_ready  (cv_ready),
    .width_px  (pw),
    .height_px (ph),
    .out_valid (as_valid),
    .out_ready (as_ready),
    .fit_w     (fit_w),
    .fit_h     (fit_h),
    .rot       (fit_rot)
  );

  pfp_place #(.SIZE_BITS(SIZE_BITS)) u_place (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .in_valid    (as_valid),
    .in_ready    (as_ready),
    .fit_w       (fit_w),
    .fit_h       (fit_h),
    .rot         (fit_rot),
    .out_valid   (out_valid),
    .out_ready   (!out_stall),
    .dest_left   (left_u),
    .dest_top    (top_u),
    .dest_width  (dest_width),
    .dest_height (dest_height),
    .rotated     (rotated)
  );

  assign dest_left = left_u;
  assign dest_top  = top_u;
  assign in_stall  = !in_ready;

`ifndef SYNTHESIS
  a_stall_needs_result: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid)
    else $error("input stalled while no result is waiting");

  a_rotate_needs_mode: assert property (@(posedge clk) disable iff (rst)
    out_valid && rotated |-> cfg.mode[pfp_pkg::MODE_AUTOROT])
    else $error("rotated result without autorotate");

  a_origin_without_center: assert property (@(posedge clk) disable iff (rst)
    out_valid && !cfg.mode[pfp_pkg::MODE_CENTER] |->
      (dest_left == {cfg.left[pfp_pkg::BND_W-1], cfg.left}) &&
      (dest_top == {cfg.top[pfp_pkg::BND_W-1], cfg.top}))
    else $error("uncentered result moved off the bounds origin");
`endif

endmodule

>>> tb/sv/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Page fit placement testbench
// Drives page sizes through the block under several register settings, with
// random input gaps and output stalls, and checks every placed rectangle
// against a behavioral prediction kept in a small scoreboard class.
// ----------------------------------------------------------------------------
module testbench;

  typedef logic [pfp_pkg::PTS_W-1:0]      pts_t;
  typedef logic [pfp_pkg::CFG_DATA_W-1:0] cfg_word_t;

  typedef struct {
    logic signed [pfp_pkg::POS_W-1:0] left;
    logic signed [pfp_pkg::POS_W-1:0] top;
    logic [pfp_pkg::BND_W-1:0]        width;
    logic [pfp_pkg::BND_W-1:0]        height;
    logic                             rot;
  } placement_t;

  class placement_board;
    pfp_pkg::cfg_t cfg;
    placement_t    pending[$];
    int            errors;

    function void set_reg(logic [pfp_pkg::CFG_IDX_W-1:0] idx, cfg_word_t d);
      case (idx)
        pfp_pkg::REG_DPI_H: cfg.dpi_h = d[pfp_pkg::DPI_W-1:0];
        pfp_pkg::REG_DPI_V: cfg.dpi_v = d[pfp_pkg::DPI_W-1:0];
        pfp_pkg::REG_LEFT:  cfg.left  = d;
        pfp_pkg::REG_TOP:   cfg.top   = d;
        pfp_pkg::REG_WIDE:  cfg.wide  = d;
        pfp_pkg::REG_TALL:  cfg.tall  = d;
        pfp_pkg::REG_MODE:  cfg.mode  = d[pfp_pkg::MODE_W-1:0];
        default: ;
      endcase
    endfunction

    function longint px(longint pts, longint dpi);
      longint p;
      p = pts * dpi / 1152;
      return (p > 65535) ? 65535 : p;
    endfunction

    function longint resize(longint v, longint ax, longint dpi);
      if (cfg.dpi_h == cfg.dpi_v || dpi == 0) return v;
      return v * ax / dpi;
    endfunction

    function void note_page(pts_t pw_pts, pts_t ph_pts);
      longint dpi, pw, ph, bw, bh, w, h, t, lf, tp, rw, rh;
      bit scale;
      placement_t p;
      dpi = (cfg.dpi_h > cfg.dpi_v) ? cfg.dpi_h : cfg.dpi_v;
      pw = px(pw_pts, dpi);
      ph = px(ph_pts, dpi);
      bw = cfg.wide;
      bh = cfg.tall;
      lf = cfg.left;
      tp = cfg.top;
      p.rot = 0;
      scale = 0;
      if (cfg.mode[pfp_pkg::MODE_AUTOROT] && ((bw > bh) != (pw > ph))) begin
        p.rot = 1;
        t = pw; pw = ph; ph = t;
      end
      if (cfg.mode[pfp_pkg::MODE_FIT] && (pw > bw || ph > bh)) scale = 1;
      else if (cfg.mode[pfp_pkg::MODE_STRETCH] && (pw < bw || ph < bh)) scale = 1;
      if (scale) begin
        w = bw;
        h = bh;
        if (cfg.mode[pfp_pkg::MODE_KEEP]) begin
          if (pw * bh > ph * bw) h = ph * bw / pw;
          else w = (ph == 0) ? 0 : pw * bh / ph;
        end
      end else begin
        w = pw;
        h = ph;
      end
      w = resize(w, cfg.dpi_h, dpi);
      h = resize(h, cfg.dpi_v, dpi);
      if (cfg.mode[pfp_pkg::MODE_CENTER]) begin
        rw = resize(bw, cfg.dpi_h, dpi);
        rh = resize(bh, cfg.dpi_v, dpi);
        lf += (rw - w) / 2;
        tp += (rh - h) / 2;
      end
      p.left = lf[pfp_pkg::POS_W-1:0];
      p.top = tp[pfp_pkg::POS_W-1:0];
      p.width = w[pfp_pkg::BND_W-1:0];
      p.height = h[pfp_pkg::BND_W-1:0];
      pending.push_back(p);
    endfunction

    function void check(placement_t a);
      placement_t e;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result transaction", $time);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (a.left !== e.left) begin
        $display("%0t: dest_left expected %0d actual %0d", $time, e.left, a.left);
        errors++;
      end
      if (a.top !== e.top) begin
        $display("%0t: dest_top expected %0d actual %0d", $time, e.top, a.top);
        errors++;
      end
      if (a.width !== e.width) begin
        $display("%0t: dest_width expected %0d actual %0d", $time, e.width, a.width);
        errors++;
      end
      if (a.height !== e.height) begin
        $display("%0t: dest_height expected %0d actual %0d", $time, e.height,
                 a.height);
        errors++;
      end
      if (a.rot !== e.rot) begin
        $display("%0t: rotated expected %0d actual %0d", $time, e.rot, a.rot);
        errors++;
      end
    endfunction
  endclass

  localparam int LATENCY = 25;
  localparam int IDLE_LIMIT = 5000;

  logic clk = 0, rst = 1;
  logic cfg_valid = 0, cfg_ready;
  logic [pfp_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  cfg_word_t cfg_data = '0;
  logic in_valid = 0, in_stall;
  pts_t page_width_pts = '0, page_height_pts = '0;
  logic out_valid, out_stall = 0;
  logic signed [pfp_pkg::POS_W-1:0] dest_left, dest_top;
  logic [pfp_pkg::BND_W-1:0] dest_width, dest_height;
  logic rotated;

  placement_board board;
  int idle_cycles;
  bit stall_run;

  page_fit_placement i_dut (.*);

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      placement_t a;
      a.left = dest_left;
      a.top = dest_top;
      a.width = dest_width;
      a.height = dest_height;
      a.rot = rotated;
      board.check(a);
    end
  end

  // The receiver stalls in runs: some long free stretches, some heavy stalling.
  always @(posedge clk) begin
    if ($urandom_range(0, 63) == 0) stall_run <= !stall_run;
    out_stall <= stall_run ? ($urandom_range(0, 3) != 0) : ($urandom_range(0, 9) == 0);
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || rst) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("FAIL page_fit_placement");
      $finish;
    end
  end

  task automatic write_reg(logic [pfp_pkg::CFG_IDX_W-1:0] idx, cfg_word_t d);
    cfg_valid <= 1;
    cfg_index <= idx;
    cfg_data <= d;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    board.set_reg(idx, d);
    cfg_valid <= 0;
  endtask

  task automatic send_page(pts_t w, pts_t h);
    in_valid <= 1;
    page_width_pts <= w;
    page_height_pts <= h;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    board.note_page(w, h);
  endtask

  task automatic pause_sender();
    in_valid <= 0;
    @(posedge clk);
  endtask

  task automatic drain();
    while (board.pending.size() != 0) @(posedge clk);
    repeat (LATENCY + 5) @(posedge clk);
  endtask

  function automatic pts_t rand_pts();
    case ($urandom_range(0, 4))
      0: return pts_t'($urandom_range(0, 40));
      1: return pts_t'($urandom);
      2: return pts_t'($urandom_range(0, 16000));
      default: return pts_t'($urandom_range(1000, 20000));
    endcase
  endfunction

  task automatic random_pages(int n);
    int burst;
    while (n > 0) begin
      burst = $urandom_range(1, 30);
      while (burst > 0 && n > 0) begin
        send_page(rand_pts(), rand_pts());
        burst--;
        n--;
      end
      if ($urandom_range(0, 2) != 0) begin
        pause_sender();
        repeat ($urandom_range(0, 12)) @(posedge clk);
      end
    end
    pause_sender();
  endtask

  function automatic cfg_word_t rand_dpi();
    case ($urandom_range(0, 4))
      0: return 1;
      1: return 4800;
      2: return 72;
      default: return cfg_word_t'($urandom_range(1, 4800));
    endcase
  endfunction

  function automatic cfg_word_t rand_size();
    case ($urandom_range(0, 3))
      0: return 1;
      1: return 65535;
      default: return cfg_word_t'($urandom_range(1, 3000));
    endcase
  endfunction

  initial begin
    board = new();
    board.cfg = '{dpi_h: pfp_pkg::DPI_RESET, dpi_v: pfp_pkg::DPI_RESET, left: 0, top: 0,
                  wide: pfp_pkg::SIZE_RESET, tall: pfp_pkg::SIZE_RESET, mode: 0};
    repeat (4) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // Directed: field extremes under the reset settings, then special cases.
    send_page(0, 0);
    send_page(20'hFFFFF, 20'hFFFFF);
    send_page(20'hFFFFF, 0);
    send_page(1152, 1);
    pause_sender();
    drain();
    write_reg(pfp_pkg::REG_WIDE, 400);
    write_reg(pfp_pkg::REG_TALL, 300);
    write_reg(pfp_pkg::REG_LEFT, 16'h8000);
    write_reg(pfp_pkg::REG_TOP, 16'h7FFF);
    write_reg(pfp_pkg::REG_MODE, 5'b11011);
    send_page(9000, 0);
    send_page(0, 9000);
    send_page(0, 0);
    send_page(20'hFFFFF, 5000);
    send_page(1000, 20000);
    pause_sender();
    drain();
    write_reg(pfp_pkg::REG_MODE, 5'b11101);
    send_page(0, 0);
    send_page(100, 100);
    send_page(3000, 2000);
    pause_sender();
    drain();
    write_reg(pfp_pkg::REG_DPI_H, 4800);
    write_reg(pfp_pkg::REG_DPI_V, 1);
    write_reg(pfp_pkg::REG_MODE, 5'b11111);
    send_page(16000, 12000);
    send_page(20'hFFFFF, 20'hFFFFF);
    send_page(0, 20'hFFFFF);
    pause_sender();
    drain();

    for (int phase = 0; phase < 12; phase++) begin
      write_reg(pfp_pkg::REG_DPI_H, rand_dpi());
      write_reg(pfp_pkg::REG_DPI_V,
                ($urandom_range(0, 2) == 0) ? cfg_word_t'(board.cfg.dpi_h) : rand_dpi());
      write_reg(pfp_pkg::REG_LEFT, cfg_word_t'($urandom));
      write_reg(pfp_pkg::REG_TOP, cfg_word_t'($urandom));
      write_reg(pfp_pkg::REG_WIDE, rand_size());
      write_reg(pfp_pkg::REG_TALL, rand_size());
      write_reg(pfp_pkg::REG_MODE,
                cfg_word_t'((phase < 2) ? phase * 31 : $urandom_range(0, 31)));
      random_pages(100);
      drain();
    end

    if (board.errors == 0) begin
      $display("PASS page_fit_placement");
    end else begin
      $display("FAIL page_fit_placement");
    end
    $finish;
  end
endmodule
